### src/bw3_pkg.sv
// ============================================================================
// bw3_pkg: shared types and constants for the barycentric weight pipeline
// Holds the coordinate and weight formats, the internal word widths that
// follow from them, and the packed input and output words.
// ============================================================================
`default_nettype none

package bw3_pkg;

  // Coordinate width of one input field (two's complement).
  localparam int COORD_WIDTH      = 32;
  // Fraction bits of each output weight.
  localparam int WEIGHT_FRAC_BITS = 24;
  // Width of one output weight.
  localparam int WEIGHT_W         = 32;

  // Edge vector component width.
  localparam int DW  = COORD_WIDTH + 1;
  // Dot product width: three products of DW by DW bits.
  localparam int PW  = 2 * DW + 2;
  // Cramer determinant width: difference of two PW by PW products.
  localparam int QW  = 2 * PW + 1;
  // Numerator width: weight a numerator is abc - atc - abt.
  localparam int NW  = QW + 2;
  // Divider remainder width: numerator magnitude scaled, or divisor shifted.
  localparam int RW  = NW + WEIGHT_W;

  // One input word: three vertices and the query point.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic signed [COORD_WIDTH-1:0] t_x;
    logic signed [COORD_WIDTH-1:0] t_y;
    logic signed [COORD_WIDTH-1:0] t_z;
  } in_word_t;

  // One output word: three weights and two flags.
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
    logic                       degenerate;
    logic                       saturated;
  } out_word_t;

endpackage

`default_nettype wire

### src/barycentric_weights_3d.sv
// ============================================================================
// barycentric_weights_3d: barycentric weights of a point in a 3D triangle
// Forms edge vectors and dot products, the Cramer determinants, and three
// exact quotients scaled to signed Q8.24 with truncation and saturation.
// ============================================================================
//
//   port group   direction  handshake               word
//   in_*         input      in_valid_i / in_stall_o  bw3_pkg::in_word_t
//   out_*        output     out_valid_o / out_stall_i bw3_pkg::out_word_t
//
// One word is taken in every cycle unless the output stall freezes the pipeline.
// The 32-step restoring divider produces one quotient bit a stage.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// A stall on the output with a result waiting freezes the whole pipeline,
// and the input then stalls in the same cycle.
//
`default_nettype none

module barycentric_weights_3d (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bw3_pkg::in_word_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bw3_pkg::out_word_t       out_data_o
);

  localparam int FB    = bw3_pkg::WEIGHT_FRAC_BITS;
  localparam int WW    = bw3_pkg::WEIGHT_W;
  localparam int DW    = bw3_pkg::DW;
  localparam int PW    = bw3_pkg::PW;
  localparam int QW    = bw3_pkg::QW;
  localparam int NW    = bw3_pkg::NW;
  localparam int RW    = bw3_pkg::RW;
  localparam int STEPS = WW;
  localparam int LAST  = 10 + STEPS;

  // Dot product lanes.
  localparam int D_ABAB = 0;
  localparam int D_ABAC = 1;
  localparam int D_ACAC = 2;
  localparam int D_ATAB = 3;
  localparam int D_ATAC = 4;

  // Weight lanes.
  localparam int L_A = 0;
  localparam int L_B = 1;
  localparam int L_C = 2;

  logic            en;
  logic [LAST:1]   v_q;

  // Pipeline advances unless a finished word is held at the output.
  assign en         = !(v_q[LAST] && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:1], in_valid_i};
    end
  end

  // Stage 1: edge vectors ab, ac and at.
  logic signed [DW-1:0] ab_q [3];
  logic signed [DW-1:0] ac_q [3];
  logic signed [DW-1:0] at_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab_q[0] <= DW'(in_data_i.b_x) - DW'(in_data_i.a_x);
      ab_q[1] <= DW'(in_data_i.b_y) - DW'(in_data_i.a_y);
      ab_q[2] <= DW'(in_data_i.b_z) - DW'(in_data_i.a_z);
      ac_q[0] <= DW'(in_data_i.c_x) - DW'(in_data_i.a_x);
      ac_q[1] <= DW'(in_data_i.c_y) - DW'(in_data_i.a_y);
      ac_q[2] <= DW'(in_data_i.c_z) - DW'(in_data_i.a_z);
      at_q[0] <= DW'(in_data_i.t_x) - DW'(in_data_i.a_x);
      at_q[1] <= DW'(in_data_i.t_y) - DW'(in_data_i.a_y);
      at_q[2] <= DW'(in_data_i.t_z) - DW'(in_data_i.a_z);
    end
  end

  // Stages 2 and 3: the fifteen component products of the dot products.
  logic signed [DW-1:0]   dop_a [5][3];
  logic signed [DW-1:0]   dop_b [5][3];
  logic signed [2*DW-1:0] dprod [5][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dop_a[D_ABAB][k] = ab_q[k];
      dop_b[D_ABAB][k] = ab_q[k];
      dop_a[D_ABAC][k] = ab_q[k];
      dop_b[D_ABAC][k] = ac_q[k];
      dop_a[D_ACAC][k] = ac_q[k];
      dop_b[D_ACAC][k] = ac_q[k];
      dop_a[D_ATAB][k] = at_q[k];
      dop_b[D_ATAB][k] = ab_q[k];
      dop_a[D_ATAC][k] = at_q[k];
      dop_b[D_ATAC][k] = ac_q[k];
    end
  end

  for (genvar d = 0; d < 5; d++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_cmp
      bw3_mul #(.W(DW)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (dop_a[d][k]),
        .b_i   (dop_b[d][k]),
        .p_o   (dprod[d][k])
      );
    end
  end

  // Stage 4: dot product sums.
  logic signed [PW-1:0] dot_q [5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 5; d++) begin
        dot_q[d] <= PW'(dprod[d][0]) + PW'(dprod[d][1]) + PW'(dprod[d][2]);
      end
    end
  end

  // Stages 5 and 6: the six products of Cramer's rule.
  logic signed [PW-1:0]   cop_a [6];
  logic signed [PW-1:0]   cop_b [6];
  logic signed [2*PW-1:0] cprod [6];

  always_comb begin
    cop_a[0] = dot_q[D_ABAB];  cop_b[0] = dot_q[D_ACAC];
    cop_a[1] = dot_q[D_ABAC];  cop_b[1] = dot_q[D_ABAC];
    cop_a[2] = dot_q[D_ABAB];  cop_b[2] = dot_q[D_ATAC];
    cop_a[3] = dot_q[D_ABAC];  cop_b[3] = dot_q[D_ATAB];
    cop_a[4] = dot_q[D_ACAC];  cop_b[4] = dot_q[D_ATAB];
    cop_a[5] = dot_q[D_ABAC];  cop_b[5] = dot_q[D_ATAC];
  end

  for (genvar m = 0; m < 6; m++) begin : g_cram
    bw3_mul #(.W(PW)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (cop_a[m]),
      .b_i   (cop_b[m]),
      .p_o   (cprod[m])
    );
  end

  // Stage 7: the determinants abc, atc and abt.
  logic signed [QW-1:0] abc_q, atc_q, abt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      abc_q <= QW'(cprod[0]) - QW'(cprod[1]);
      atc_q <= QW'(cprod[2]) - QW'(cprod[3]);
      abt_q <= QW'(cprod[4]) - QW'(cprod[5]);
    end
  end

  // Stage 8: numerators of the three weights and the degenerate test.
  logic signed [NW-1:0] num_q [3];
  logic [QW-1:0]        den8_q;
  logic                 deg8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q[L_A] <= NW'(abc_q) - NW'(atc_q) - NW'(abt_q);
      num_q[L_B] <= NW'(abt_q);
      num_q[L_C] <= NW'(atc_q);
      den8_q     <= abc_q;
      deg8_q     <= (abc_q == '0);
    end
  end

  // Stage 9 (divider step 0): sign, scaled magnitude and the overflow test.
  // A quotient of 2^32 or more shows up as mag >= den << (32 - F).
  logic [RW-1:0] rem_q  [STEPS+1][3];
  logic [WW-1:0] quo_q  [STEPS+1][3];
  logic          neg_q  [STEPS+1][3];
  logic          high_q [STEPS+1][3];
  logic [QW-1:0] den_q  [STEPS+1];
  logic          deg_q  [STEPS+1];
  logic [NW-1:0] mag    [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = num_q[l][NW-1] ? NW'(-num_q[l]) : NW'(num_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l]  <= RW'(mag[l]) << FB;
        quo_q[0][l]  <= '0;
        neg_q[0][l]  <= num_q[l][NW-1];
        high_q[0][l] <= (RW'(mag[l]) >= (RW'(den8_q) << (WW - FB)));
      end
      den_q[0] <= den8_q;
      deg_q[0] <= deg8_q;
    end
  end

  // Divider steps: one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= STEPS; j++) begin : g_div
    localparam int Bit = STEPS - j;

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW-1:0] shifted;
      logic          fits;

      assign shifted = RW'(den_q[j-1]) << Bit;
      assign fits    = (rem_q[j-1][l] >= shifted);

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[j][l]  <= fits ? (rem_q[j-1][l] - shifted) : rem_q[j-1][l];
          quo_q[j][l]  <= quo_q[j-1][l] | (WW'(fits) << Bit);
          neg_q[j][l]  <= neg_q[j-1][l];
          high_q[j][l] <= high_q[j-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[j] <= den_q[j-1];
        deg_q[j] <= deg_q[j-1];
      end
    end
  end

  // Final stage: sign, saturation and the degenerate override.
  logic [WW-1:0] limit  [3];
  logic          clip   [3];
  logic [WW-1:0] weight [3];
  logic          any_clip;
  bw3_pkg::out_word_t out_d, out_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      limit[l]  = neg_q[STEPS][l] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
      clip[l]   = high_q[STEPS][l] || (quo_q[STEPS][l] > limit[l]);
      if (clip[l]) begin
        weight[l] = limit[l];
      end else if (neg_q[STEPS][l]) begin
        weight[l] = WW'(-quo_q[STEPS][l]);
      end else begin
        weight[l] = quo_q[STEPS][l];
      end
    end
    any_clip = clip[L_A] || clip[L_B] || clip[L_C];

    if (deg_q[STEPS]) begin
      out_d.weight_a   = '0;
      out_d.weight_b   = '0;
      out_d.weight_c   = '0;
      out_d.degenerate = 1'b1;
      out_d.saturated  = 1'b0;
    end else begin
      out_d.weight_a   = weight[L_A];
      out_d.weight_b   = weight[L_B];
      out_d.weight_c   = weight[L_C];
      out_d.degenerate = 1'b0;
      out_d.saturated  = any_clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[LAST];
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### src/bw3_mul.sv
// ============================================================================
// bw3_mul: two-stage signed multiplier
// Splits both operands into a signed high half and an unsigned low half,
// registers the four partial products, then adds them in the second stage.
// ============================================================================
`default_nettype none

module bw3_mul #(
  parameter int W = 34
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [W-1:0]   a_i,
  input  wire logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0]      p_o
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;
  localparam int PW2 = 2 * W;

  logic signed [HW-1:0]  a_hi, b_hi;
  logic signed [H:0]     a_lo, b_lo;
  logic signed [PW2-1:0] hh_q, hl_q, lh_q, ll_q;
  logic signed [PW2-1:0] p_q;

  // Operand halves; the low half carries a zero sign bit.
  assign a_hi = a_i[W-1:H];
  assign b_hi = b_i[W-1:H];
  assign a_lo = {1'b0, a_i[H-1:0]};
  assign b_lo = {1'b0, b_i[H-1:0]};

  // First stage: partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= PW2'(a_hi) * PW2'(b_hi);
      hl_q <= PW2'(a_hi) * PW2'(b_lo);
      lh_q <= PW2'(a_lo) * PW2'(b_hi);
      ll_q <= PW2'(a_lo) * PW2'(b_lo);
    end
  end

  // Second stage: weighted sum of the partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (hh_q <<< (2 * H)) + ((hl_q + lh_q) <<< H) + ll_q;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
